>>> rtl/rtn_pkg.sv
// Shared types and arithmetic helpers for the ray/triangle nearest-hit block.
package rtn_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int W = 32;
    localparam int PW = 2 * W;
    localparam int QDEPTH = 2;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_DET_EPS  = 3'd6;

    typedef logic signed [W-1:0] fx_t;
    typedef fx_t vec_t [3];

    typedef struct packed {
        fx_t ax, ay, az, bx, by, bz, cx, cy, cz;
        logic last;
    } tri_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE, ST_P, ST_DET, ST_U, ST_Q, ST_VNUM, ST_V, ST_T, ST_UPD, ST_PT,
        ST_OUT
    } state_t;

    function automatic fx_t sat32(input logic signed [PW+1:0] v);
        logic signed [PW+1:0] mx, mn;
        mx = '0;
        mx[W-2:0] = '1;
        mn = ~mx;
        if (v > mx) return fx_t'(32'h7fffffff);
        if (v < mn) return fx_t'(32'h80000000);
        return v[W-1:0];
    endfunction

    // floor(a*b / 2^F): arithmetic shift of the exact product
    function automatic logic signed [PW-1:0] mulq(input fx_t a, input fx_t b);
        logic signed [PW-1:0] pr;
        pr = PW'(a) * PW'(b);
        return pr >>> FRACTION_BITS;
    endfunction

    function automatic fx_t sub_sat(input fx_t a, input fx_t b);
        return sat32((PW+2)'(a) - (PW+2)'(b));
    endfunction

endpackage

>>> rtl/rtn_front.sv
// Front end: accept triangles into a short queue.
module rtn_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rtn_pkg::tri_t in_tri,
    output logic          q_valid,
    input  logic          q_pop,
    output rtn_pkg::tri_t q_tri
);
    import rtn_pkg::*;

    tri_t       mem [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = cnt_reg != 2'(QDEPTH);
    assign push     = in_valid && in_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_tri    = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= in_tri;
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

>>> rtl/rtn_div.sv
// Iterative signed divider: (n << F) / d, truncating, saturated to 32 bits.
module rtn_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  rtn_pkg::fx_t num,
    input  rtn_pkg::fx_t den,
    output logic        done,
    output rtn_pkg::fx_t quo
);
    import rtn_pkg::*;

    localparam int NB = W + FRACTION_BITS;
    logic [NB-1:0] n_reg, q_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    r_reg, r_try;
    logic [5:0]    cnt_reg;
    logic          neg_reg, busy_reg;
    logic [NB:0]   sq;
    logic [W:0]    mag;

    assign mag   = num[W-1] ? -{num[W-1], num} : {num[W-1], num};
    assign r_try = {r_reg[W-1:0], n_reg[NB-1]} - {1'b0, d_reg};
    assign done  = busy_reg && cnt_reg == 6'd0;
    assign sq    = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign quo   = sat32((PW+2)'(signed'(sq)));

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= NB'(mag) << FRACTION_BITS;
            d_reg   <= den[W-1] ? W'(-den) : W'(den);
            neg_reg <= num[W-1] ^ den[W-1];
            r_reg   <= '0;
            q_reg   <= '0;
            cnt_reg <= 6'(NB);
        end else if (busy_reg && cnt_reg != 6'd0) begin
            n_reg <= n_reg << 1;
            if (!r_try[W]) begin
                r_reg <= r_try;
                q_reg <= {q_reg[NB-2:0], 1'b1};
            end else begin
                r_reg <= {r_reg[W-1:0], n_reg[NB-1]};
                q_reg <= {q_reg[NB-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (!aresetn) busy_reg <= 1'b0;
        else if (start) busy_reg <= 1'b1;
        else if (done) busy_reg <= 1'b0;
    end
endmodule

>>> rtl/rtn_back.sv
// Back end: Moller-Trumbore sequencer, nearest-hit tracking and result register.
module rtn_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  rtn_pkg::vec_t org,
    input  rtn_pkg::vec_t dir,
    input  logic [30:0]   eps,
    input  logic          q_valid,
    output logic          q_pop,
    input  rtn_pkg::tri_t q_tri,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_hit_found,
    output rtn_pkg::fx_t  m_hit_distance,
    output rtn_pkg::vec_t m_point,
    output rtn_pkg::vec_t m_normal
);
    import rtn_pkg::*;

    state_t state_reg, state_next;
    tri_t   t_reg;
    vec_t   e1_reg, e2_reg, s_reg, p_reg, q_reg, n_reg, pt_reg;
    fx_t    det_reg, u_reg, v_reg, t_reg2, dn_reg, dot_v;
    logic [1:0] k_reg;
    logic   dstart_reg;
    fx_t    dnum;
    logic   ddone;
    fx_t    dq;
    logic   bf_reg;
    fx_t    bd_reg;
    vec_t   bp_reg, bn_reg;
    logic   ov_reg;

    rtn_div u_div (.aclk, .aresetn, .start(dstart_reg), .num(dnum), .den(det_reg),
                   .done(ddone), .quo(dq));
    assign dnum = dn_reg;

    function automatic fx_t dot(input vec_t a, input vec_t b);
        return sat32((PW+2)'(mulq(a[0], b[0])) + (PW+2)'(mulq(a[1], b[1]))
                     + (PW+2)'(mulq(a[2], b[2])));
    endfunction

    // one component of a x b; index selects the component
    function automatic fx_t crs(input vec_t a, input vec_t b, input logic [1:0] i);
        logic [1:0] j, l;
        j = (i == 2'd2) ? 2'd0 : i + 2'd1;
        l = (j == 2'd2) ? 2'd0 : j + 2'd1;
        return sat32((PW+2)'(mulq(a[j], b[l])) - (PW+2)'(mulq(a[l], b[j])));
    endfunction

    assign q_pop  = state_reg == ST_IDLE && q_valid;
    assign m_valid = ov_reg;

    always_comb begin
        state_next = state_reg;
        dot_v = dot(e1_reg, p_reg);
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_EDGE;
            ST_EDGE: state_next = ST_P;
            ST_P:    if (k_reg == 2'd2) state_next = ST_DET;
            ST_DET: begin
                if (dot_v == '0 || ((W+1)'(dot_v) > -$signed({2'b00, eps})
                    && (W+1)'(dot_v) < $signed({2'b00, eps})))
                    state_next = ST_UPD;
                else state_next = ST_U;
            end
            ST_U: if (ddone) state_next = (dq < 0 || dq > fx_t'(1 << FRACTION_BITS))
                                        ? ST_UPD : ST_Q;
            ST_Q: if (k_reg == 2'd2) state_next = ST_VNUM;
            ST_VNUM: state_next = ST_V;
            ST_V: if (ddone) state_next = (dq < 0 ||
                    (W+2)'(u_reg) + (W+2)'(dq) > (W+2)'(1 << FRACTION_BITS))
                                        ? ST_UPD : ST_T;
            ST_T: if (ddone) state_next = ST_PT;
            ST_PT: if (k_reg == 2'd2) state_next = ST_UPD;
            ST_UPD: state_next = t_reg.last ? ST_OUT : ST_IDLE;
            ST_OUT: if (!ov_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic hit_reg;

    always_ff @(posedge aclk) begin
        dstart_reg <= 1'b0;
        case (state_reg)
            ST_IDLE: if (q_valid) begin t_reg <= q_tri; k_reg <= 2'd0; hit_reg <= 1'b0; end
            ST_EDGE: begin
                e1_reg <= '{sub_sat(t_reg.bx, t_reg.ax), sub_sat(t_reg.by, t_reg.ay),
                            sub_sat(t_reg.bz, t_reg.az)};
                e2_reg <= '{sub_sat(t_reg.cx, t_reg.ax), sub_sat(t_reg.cy, t_reg.ay),
                            sub_sat(t_reg.cz, t_reg.az)};
                s_reg  <= '{sub_sat(org[0], t_reg.ax), sub_sat(org[1], t_reg.ay),
                            sub_sat(org[2], t_reg.az)};
            end
            ST_P: begin
                p_reg[k_reg] <= crs(dir, e2_reg, k_reg);
                n_reg[k_reg] <= crs(e1_reg, e2_reg, k_reg);
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            ST_DET: begin
                det_reg <= dot_v;
                dn_reg <= dot(s_reg, p_reg);
                if (state_next == ST_U) dstart_reg <= 1'b1;
            end
            ST_U: if (ddone) u_reg <= dq;
            ST_Q: begin
                q_reg[k_reg] <= crs(s_reg, e1_reg, k_reg);
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            ST_VNUM: begin
                dn_reg <= dot(dir, q_reg);
                dstart_reg <= 1'b1;
            end
            ST_V: if (ddone) begin
                v_reg <= dq;
                dn_reg <= dot(e2_reg, q_reg);
                if (state_next == ST_T) dstart_reg <= 1'b1;
            end
            ST_T: if (ddone) t_reg2 <= dq;
            ST_PT: begin
                pt_reg[k_reg] <= sat32((PW+2)'(org[k_reg]) + (PW+2)'(mulq(dir[k_reg], t_reg2)));
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                if (k_reg == 2'd2) hit_reg <= 1'b1;
            end
            default: ;
        endcase
        if (state_reg == ST_OUT && (!ov_reg || m_ready)) begin
            m_hit_found    <= bf_reg;
            m_hit_distance <= bd_reg;
            m_point        <= bp_reg;
            m_normal       <= bn_reg;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            bf_reg <= 1'b0;
            bd_reg <= '0;
            bp_reg <= '{default: '0};
            bn_reg <= '{default: '0};
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_UPD && hit_reg && (!bf_reg || t_reg2 < bd_reg)) begin
                bf_reg <= 1'b1;
                bd_reg <= t_reg2;
                bp_reg <= pt_reg;
                bn_reg <= n_reg;
            end
            if (state_reg == ST_OUT && (!ov_reg || m_ready)) begin
                ov_reg <= 1'b1;
                bf_reg <= 1'b0;
                bd_reg <= '0;
                bp_reg <= '{default: '0};
                bn_reg <= '{default: '0};
            end else if (ov_reg && m_ready) ov_reg <= 1'b0;
        end
    end
endmodule

>>> rtl/ray_triangle_nearest_hit.sv
// Top level of the ray/triangle nearest-hit block.
//
//  channel  direction  beat carries
//  s_       in         one triangle (three vertices, last flag)
//  cfg_     in         register index and write data
//  m_       out        nearest hit of a finished list
//
// A hit in the back end runs three divisions (u, v and t) in the shared
// divider, each a start, 48 restoring steps and a done, and builds the
// cross products and the hit point one component at a time; a determinant
// miss ends without a division.
// A two-entry queue takes beats while the back end works. Reset is
// synchronous on aresetn and clears queue, sequencer, kept hit and output.
// The result register holds a beat until m_ready; the back end stalls on it.
module ray_triangle_nearest_hit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_a_x, input logic [31:0] s_a_y, input logic [31:0] s_a_z,
    input  logic [31:0] s_b_x, input logic [31:0] s_b_y, input logic [31:0] s_b_z,
    input  logic [31:0] s_c_x, input logic [31:0] s_c_y, input logic [31:0] s_c_z,
    input  logic        s_last_triangle,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit_found,
    output logic [31:0] m_hit_distance,
    output logic [31:0] m_point_x, output logic [31:0] m_point_y,
    output logic [31:0] m_point_z,
    output logic [31:0] m_normal_x, output logic [31:0] m_normal_y,
    output logic [31:0] m_normal_z
);
    import rtn_pkg::*;

    vec_t  org_reg, dir_reg, pt, nm;
    logic [30:0] eps_reg;
    tri_t  in_tri, q_tri;
    logic  q_valid, q_pop;
    fx_t   hd;

    assign cfg_ready = 1'b1;
    assign in_tri = '{s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z,
                      s_c_x, s_c_y, s_c_z, s_last_triangle};

    // register file; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg <= '{default: '0};
            dir_reg <= '{32'sd0, 32'sd0, fx_t'(1 << FRACTION_BITS)};
            eps_reg <= 31'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data;
                REG_DIR_Y:    dir_reg[1] <= cfg_data;
                REG_DIR_Z:    dir_reg[2] <= cfg_data;
                REG_DET_EPS:  eps_reg    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    rtn_front u_front (.aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
                       .in_tri, .q_valid, .q_pop, .q_tri);

    rtn_back u_back (.aclk, .aresetn, .org(org_reg), .dir(dir_reg), .eps(eps_reg),
                     .q_valid, .q_pop, .q_tri, .m_valid, .m_ready,
                     .m_hit_found, .m_hit_distance(hd), .m_point(pt), .m_normal(nm));

    assign m_hit_distance = hd;
    assign m_point_x  = pt[0];
    assign m_point_y  = pt[1];
    assign m_point_z  = pt[2];
    assign m_normal_x = nm[0];
    assign m_normal_y = nm[1];
    assign m_normal_z = nm[2];
endmodule

>>> rtl/rtn_checker.sv
// Port-level checks for the nearest-hit block, bound to the top level.
module rtn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit_found,
    input logic [31:0] m_hit_distance,
    input logic [31:0] m_point_x
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_distance))
        else $error("result dropped while stalled");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit_found |-> m_hit_distance == 32'd0 && m_point_x == 32'd0)
        else $error("miss result carries data");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind ray_triangle_nearest_hit rtn_checker u_chk (.aclk, .aresetn, .m_valid, .m_ready,
    .m_hit_found, .m_hit_distance, .m_point_x);
